// ----- rtl/hrhw_pkg.sv -----
// shared types, constants and helper function of the hex record halfword writer
package hrhw_pkg;

  // widths of the record fields and of the character offset counter
  localparam int unsigned PosW   = 10;
  localparam int unsigned CountW = 8;
  localparam int unsigned HalfW  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned GathW  = 12;

  // character offsets inside one record
  localparam logic [PosW-1:0] PosMax   = 10'd1023;
  localparam logic [PosW-1:0] CountEnd = 10'd2;
  localparam logic [PosW-1:0] OffsEnd  = 10'd6;
  localparam logic [PosW-1:0] TypePos  = 10'd8;
  localparam logic [PosW-1:0] DataPos  = 10'd9;

  // ascii codes and register reset
  localparam logic [7:0]       CharZero      = 8'h30;
  localparam logic [7:0]       CharNine      = 8'h39;
  localparam logic [HalfW-1:0] AddrHighReset = 16'd2048;

  // one input character with its start flag
  typedef struct packed {
    logic [7:0] ascii_char;
    logic       record_start;
  } char_t;

  // one halfword write
  typedef struct packed {
    logic [AddrW-1:0] write_address;
    logic [HalfW-1:0] halfword;
    logic             last_of_record;
  } result_t;

  // ascii hex digit to nibble, letters as code minus 55 modulo 16
  function automatic logic [3:0] to_nibble(logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CharZero) && (c <= CharNine);
    return is_digit ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

endpackage

// ----- rtl/hrhw_in_if.sv -----
// character channel: valid, ready and one record character
interface hrhw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       record_start;

  modport source (output valid, output ascii_char, output record_start, input ready);
  modport sink   (input valid, input ascii_char, input record_start, output ready);
endinterface

// ----- rtl/hrhw_out_if.sv -----
// halfword channel: valid, ready and one halfword write
interface hrhw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [15:0] halfword;
  logic        last_of_record;

  modport source (output valid, output write_address, output halfword,
                  output last_of_record, input ready);
  modport sink   (input valid, input write_address, input halfword,
                  input last_of_record, output ready);
endinterface

// ----- rtl/hrhw_in_stage.sv -----
// input register stage holding one accepted character
module hrhw_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  hrhw_in_if.sink          in_i,
  output logic             char_valid_o,
  output hrhw_pkg::char_t  char_o,
  input  logic             char_ready_i
);

  logic            valid_q;
  hrhw_pkg::char_t data_q;
  logic            take;

  // stage frees up when empty or when the parser takes the character
  assign take       = valid_q && char_ready_i;
  assign in_i.ready = !valid_q || char_ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  // character payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q.ascii_char   <= in_i.ascii_char;
      data_q.record_start <= in_i.record_start;
    end
  end

  assign char_valid_o = valid_q;
  assign char_o       = data_q;

endmodule

// ----- rtl/hrhw_parser.sv -----
// record parser: offset tracking, header fields and halfword assembly
module hrhw_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hrhw_pkg::HalfW-1:0]  cfg_wdata_i,
  input  logic                        char_valid_i,
  input  hrhw_pkg::char_t             char_i,
  output logic                        char_ready_o,
  output logic                        res_valid_o,
  output hrhw_pkg::result_t           res_o,
  input  logic                        res_ready_i
);

  logic [hrhw_pkg::HalfW-1:0]  addr_high_q;
  logic [hrhw_pkg::PosW-1:0]   char_pos_q, char_pos_d;
  logic [hrhw_pkg::CountW-1:0] byte_count_q, byte_count_d;
  logic [hrhw_pkg::HalfW-1:0]  addr_offs_q, addr_offs_d;
  logic                        rec_en_q, rec_en_d;
  logic [hrhw_pkg::GathW-1:0]  gather_q, gather_d;

  logic [hrhw_pkg::PosW-1:0]   pos;
  logic [hrhw_pkg::PosW-1:0]   data_ofs;
  logic [7:0]                  hw_idx;
  logic [1:0]                  nib_sel;
  logic [6:0]                  total;
  logic [3:0]                  nib;
  logic                        hit;
  logic                        produce;
  logic                        take;

  // offset of the current character and its place in the data field
  assign pos      = char_i.record_start ? '0 : char_pos_q;
  assign nib      = hrhw_pkg::to_nibble(char_i.ascii_char);
  assign data_ofs = pos - hrhw_pkg::DataPos;
  assign hw_idx   = data_ofs[hrhw_pkg::PosW-1:2];
  assign nib_sel  = data_ofs[1:0];
  assign total    = byte_count_q[hrhw_pkg::CountW-1:1];
  assign hit      = (pos >= hrhw_pkg::DataPos) && rec_en_q && (hw_idx < {1'b0, total});
  assign produce  = hit && (nib_sel == 2'd3);

  // a character that yields no halfword never waits on the output
  assign char_ready_o = !produce || res_ready_i;
  assign take         = char_valid_i && char_ready_o;
  assign res_valid_o  = char_valid_i && produce;

  // halfword result: first byte low, second byte high
  always_comb begin
    res_o.halfword       = {gather_q[3:0], nib, gather_q[11:8], gather_q[7:4]};
    res_o.write_address  = {addr_high_q, addr_offs_q}
                         + {{(hrhw_pkg::AddrW-8){1'b0}}, hw_idx[6:0], 1'b0};
    res_o.last_of_record = ((hw_idx + 8'd1) == {1'b0, total});
  end

  // next state for one character
  always_comb begin
    char_pos_d   = (pos < hrhw_pkg::PosMax) ? pos + 10'd1 : hrhw_pkg::PosMax;
    byte_count_d = byte_count_q;
    addr_offs_d  = addr_offs_q;
    rec_en_d     = rec_en_q;
    gather_d     = gather_q;
    priority if (pos == '0) begin
      byte_count_d = '0;
      addr_offs_d  = '0;
      rec_en_d     = 1'b0;
      gather_d     = '0;
    end else if (pos <= hrhw_pkg::CountEnd) begin
      byte_count_d = {byte_count_q[3:0], nib};
    end else if (pos <= hrhw_pkg::OffsEnd) begin
      addr_offs_d = {addr_offs_q[11:0], nib};
    end else if (pos == hrhw_pkg::TypePos) begin
      rec_en_d = (char_i.ascii_char == hrhw_pkg::CharZero);
    end else if (hit) begin
      gather_d = produce ? '0 : {gather_q[7:0], nib};
    end else begin
      gather_d = gather_q;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos_q   <= '0;
      byte_count_q <= '0;
      addr_offs_q  <= '0;
      rec_en_q     <= 1'b0;
      gather_q     <= '0;
    end else if (take) begin
      char_pos_q   <= char_pos_d;
      byte_count_q <= byte_count_d;
      addr_offs_q  <= addr_offs_d;
      rec_en_q     <= rec_en_d;
      gather_q     <= gather_d;
    end
  end

  // upper address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_high_q <= hrhw_pkg::AddrHighReset;
    end else if (cfg_we_i) begin
      addr_high_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- rtl/hrhw_out_stage.sv -----
// output register holding one halfword write until the receiver takes it
module hrhw_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  hrhw_pkg::result_t  res_i,
  output logic               res_ready_o,
  hrhw_out_if.source         out_o
);

  logic              valid_q;
  hrhw_pkg::result_t data_q;
  logic              load;

  // room when empty or when the held result leaves this cycle
  assign res_ready_o = !valid_q || out_o.ready;
  assign load        = res_valid_i && res_ready_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.write_address  = data_q.write_address;
  assign out_o.halfword       = data_q.halfword;
  assign out_o.last_of_record = data_q.last_of_record;

endmodule

// ----- rtl/hex_record_halfword_writer_top.sv -----
// top level of the hex record halfword writer
//
// in_i carries record text one character per transfer; record_start marks
// the character at offset 0. out_o carries one halfword write per transfer:
// flash byte address, little-endian data halfword and a last-of-record flag.
// cfg_we_i/cfg_wdata_i write the upper 16 address bits (reset 2048); write
// only while no characters are in flight.
// A character passes an input register, is decoded combinationally by the
// parser and lands in the output register: a halfword shows on out_o once
// its fourth data character has passed the input register and the parser,
// and the output register holds it until the receiver takes it.
// Throughput is one character per cycle while no halfword waits on a stalled
// receiver, set by the parser update between the two registers.
// Reset clears the parser state, empties both registers and sets the upper
// address register to its reset value.
// When the receiver stalls, the held halfword stays on out_o; characters
// that yield no halfword keep flowing, and the first one that does waits in
// the input register, which then deasserts in_i.ready.
module hex_record_halfword_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  hrhw_in_if.sink     in_i,
  hrhw_out_if.source  out_o
);

  logic              char_valid;
  logic              char_ready;
  hrhw_pkg::char_t   char_data;
  logic              res_valid;
  logic              res_ready;
  hrhw_pkg::result_t res_data;

  // input register
  hrhw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .char_valid_o (char_valid),
    .char_o       (char_data),
    .char_ready_i (char_ready)
  );

  // record parser
  hrhw_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .char_valid_i (char_valid),
    .char_i       (char_data),
    .char_ready_o (char_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_data),
    .res_ready_i  (res_ready)
  );

  // output register
  hrhw_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_data),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/hrhw_checker.sv -----
// port-level assertions of the hex record halfword writer and their bind
module hrhw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_address_i,
  input logic [15:0] out_halfword_i,
  input logic        out_last_i
);

  // stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_address_i)
      && $stable(out_halfword_i) && $stable(out_last_i))
    else $error("stalled halfword write changed or dropped");

  // input side is never blocked while the output register has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input blocked although output can take a result");

  // nothing shows on the output right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid directly after reset");

  // the input only stalls while the output holds a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled output");

endmodule

bind hex_record_halfword_writer_top hrhw_checker u_hrhw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_address_i  (out_o.write_address),
  .out_halfword_i (out_o.halfword),
  .out_last_i     (out_o.last_of_record)
);

// ----- bench/tb_top.sv -----
// testbench of the hex record halfword writer: random record text checked against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ClkHalf      = 4;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned RandomChars  = 650;
  localparam int unsigned PhaseCount   = 5;
  localparam int unsigned MaxReports   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  hrhw_in_if  in_ch ();
  hrhw_out_if out_ch ();

  hex_record_halfword_writer_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor copy of the parser state and of the upper address register
  logic [hrhw_pkg::PosW-1:0]   next_pos;
  logic [hrhw_pkg::CountW-1:0] rec_bytes;
  logic [hrhw_pkg::HalfW-1:0]  rec_offset;
  logic                        rec_active;
  logic [hrhw_pkg::GathW-1:0]  nibbles;
  logic [6:0]                  hw_slot;
  logic [hrhw_pkg::HalfW-1:0]  upper_addr;

  hrhw_pkg::char_t   pending_chars[$];
  hrhw_pkg::result_t expected_writes[$];
  hrhw_pkg::char_t   next_char;
  hrhw_pkg::result_t oldest_write;
  int unsigned       chars_queued;
  int unsigned       error_count;
  int unsigned       cycle_count;
  int unsigned       burst_left;
  int unsigned       gap_left;
  logic [15:0]       stall_pat;
  logic [5:0]        pat_age;
  logic [15:0]       phase_upper[PhaseCount];

  // ascii character to nibble, anything but a decimal digit as code minus 55
  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [7:0] v;
    if (c >= hrhw_pkg::CharZero && c <= hrhw_pkg::CharNine) v = c - hrhw_pkg::CharZero;
    else v = c - 8'd55;
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? hrhw_pkg::CharZero + v : 8'd55 + v;
  endfunction

  // mostly upper case hex digits, some lower case, some arbitrary codes
  function automatic logic [7:0] any_digit_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'(87 + $urandom_range(10, 15));
      default: return hex_digit(4'($urandom_range(0, 15)));
    endcase
  endfunction

  function automatic logic [7:0] garble(logic [7:0] c, int unsigned noise_pct);
    return ($urandom_range(0, 99) < noise_pct) ? any_digit_char() : c;
  endfunction

  function automatic void push_char(logic [7:0] c, logic first_flag);
    pending_chars.push_back(hrhw_pkg::char_t'{ascii_char: c, record_start: first_flag});
    chars_queued++;
  endfunction

  function automatic void push_text(string s, logic first_flag);
    for (int i = 0; i < s.len(); i++) push_char(s[i], (i == 0) ? first_flag : 1'b0);
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= MaxReports) $display("mismatch: %s", msg);
  endfunction

  // one character through the predictor, expected halfword writes queued
  task automatic absorb_char(input hrhw_pkg::char_t ch);
    logic [hrhw_pkg::PosW-1:0] pos;
    logic [hrhw_pkg::PosW-1:0] data_pos;
    logic [3:0]                nib;
    int unsigned               slot;
    int unsigned               whole;
    hrhw_pkg::result_t         wr;
    pos = ch.record_start ? '0 : next_pos;
    nib = hex_value(ch.ascii_char);
    next_pos = (pos < hrhw_pkg::PosMax) ? pos + 1'b1 : hrhw_pkg::PosMax;
    if (pos == '0) begin
      rec_bytes  = '0;
      rec_offset = '0;
      rec_active = 1'b0;
      nibbles    = '0;
      hw_slot    = '0;
    end else if (pos <= hrhw_pkg::CountEnd) begin
      rec_bytes = {rec_bytes[3:0], nib};
    end else if (pos <= hrhw_pkg::OffsEnd) begin
      rec_offset = {rec_offset[11:0], nib};
    end else if (pos == hrhw_pkg::TypePos) begin
      rec_active = (ch.ascii_char == hrhw_pkg::CharZero);
    end else if (pos >= hrhw_pkg::DataPos) begin
      data_pos = pos - hrhw_pkg::DataPos;
      slot     = data_pos[hrhw_pkg::PosW-1:2];
      whole    = rec_bytes[hrhw_pkg::CountW-1:1];
      if (rec_active && slot < whole) begin
        if (data_pos[1:0] != 2'd3) begin
          nibbles = {nibbles[7:0], nib};
        end else begin
          // first record byte lands in the low byte
          hw_slot           = slot[6:0];
          wr.write_address  = {upper_addr, rec_offset} + {hw_slot, 1'b0};
          wr.halfword       = {nibbles[3:0], nib, nibbles[11:8], nibbles[7:4]};
          wr.last_of_record = (slot + 1 == whole);
          expected_writes.push_back(wr);
          nibbles = '0;
        end
      end
    end
  endtask

  // one record: header, data bytes and checksum; noise garbles header digits
  task automatic queue_record(input int unsigned data_bytes, input logic [7:0] count_field,
                              input logic [15:0] offs, input logic [7:0] type_char,
                              input logic first_flag, input int unsigned noise_pct);
    push_char(":", first_flag);
    push_char(garble(hex_digit(count_field[7:4]), noise_pct), 1'b0);
    push_char(garble(hex_digit(count_field[3:0]), noise_pct), 1'b0);
    for (int i = 3; i >= 0; i--) push_char(garble(hex_digit(offs[4*i +: 4]), noise_pct), 1'b0);
    push_char(garble(hrhw_pkg::CharZero, noise_pct), 1'b0);
    push_char(type_char, 1'b0);
    repeat (2 * data_bytes) push_char(any_digit_char(), 1'b0);
    repeat (2) push_char(hex_digit(4'($urandom)), 1'b0);
  endtask

  // mostly data records, some other types, broken records and loose noise
  task automatic queue_random_records(input int unsigned n_chars);
    int unsigned target;
    int unsigned kind;
    int unsigned nbytes;
    int unsigned size_pick;
    logic [15:0] offs;
    logic [7:0]  rec_type;
    target = chars_queued + n_chars;
    while (chars_queued < target) begin
      kind      = $urandom_range(0, 99);
      size_pick = $urandom_range(0, 49);
      if (size_pick == 0) nbytes = 255;
      else if (size_pick < 3) nbytes = $urandom_range(17, 64);
      else nbytes = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) offs = 16'hFFFF - 16'($urandom_range(0, 31));
      else offs = 16'($urandom);
      if (kind < 70) begin
        queue_record(nbytes, 8'(nbytes), offs, hrhw_pkg::CharZero, 1'b1, 0);
      end else if (kind < 80) begin
        rec_type = any_digit_char();
        if (rec_type == hrhw_pkg::CharZero) rec_type = "1";
        queue_record(nbytes, 8'(nbytes), offs, rec_type, 1'b1, 0);
      end else if (kind < 90) begin
        queue_record($urandom_range(0, 12), 8'($urandom), offs, hrhw_pkg::CharZero,
                     1'($urandom_range(0, 1)), 20);
      end else begin
        repeat ($urandom_range(1, 8)) push_char(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // wait until every character is taken and every write has come out
  task automatic settle();
    while (pending_chars.size() != 0 || in_ch.valid) @(negedge clk_i);
    while (expected_writes.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_upper_addr(input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    upper_addr   = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  // reset, directed records, then random phases under several address settings
  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.ascii_char   = '0;
    in_ch.record_start = 1'b0;
    out_ch.ready       = 1'b0;
    cycle_count        = 0;
    error_count        = 0;
    chars_queued       = 0;
    next_pos           = '0;
    rec_bytes          = '0;
    rec_offset         = '0;
    rec_active         = 1'b0;
    nibbles            = '0;
    hw_slot            = '0;
    upper_addr         = hrhw_pkg::AddrHighReset;
    phase_upper        = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8001, 16'($urandom)};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first record carries no start flag, odd byte count, top offset, extreme codes
    push_text(":03FFFE00", 1'b0);
    push_char(8'hFF, 1'b0);
    push_char("0", 1'b0);
    push_char(8'h00, 1'b0);
    push_char("f", 1'b0);
    push_text("7AC4", 1'b0);
    // zero byte count
    push_text(":00000000FF", 1'b1);
    settle();

    for (int p = 0; p < PhaseCount; p++) begin
      write_upper_addr(phase_upper[p]);
      queue_random_records(RandomChars / PhaseCount);
      settle();
    end

    if (expected_writes.size() != 0)
      note_error($sformatf("%0d writes never came out", expected_writes.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // character source: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid        <= 1'b0;
      in_ch.ascii_char   <= '0;
      in_ch.record_start <= 1'b0;
      burst_left         <= 1;
      gap_left           <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        absorb_char(hrhw_pkg::char_t'({in_ch.ascii_char, in_ch.record_start}));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_chars.size() != 0) begin
          next_char           = pending_chars.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.ascii_char   <= next_char.ascii_char;
          in_ch.record_start <= next_char.record_start;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // halfword sink: rotating stall pattern, compare each transfer with the oldest write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_pat    <= '1;
      pat_age      <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_writes.size() == 0) begin
          note_error($sformatf("unexpected write addr %h data %h last %b",
                               out_ch.write_address, out_ch.halfword, out_ch.last_of_record));
        end else begin
          oldest_write = expected_writes.pop_front();
          if (out_ch.write_address !== oldest_write.write_address ||
              out_ch.halfword !== oldest_write.halfword ||
              out_ch.last_of_record !== oldest_write.last_of_record)
            note_error($sformatf("expected addr %h data %h last %b, got addr %h data %h last %b",
                                 oldest_write.write_address, oldest_write.halfword,
                                 oldest_write.last_of_record, out_ch.write_address,
                                 out_ch.halfword, out_ch.last_of_record));
        end
      end
      out_ch.ready <= stall_pat[0];
      pat_age      <= pat_age + 1'b1;
      if (pat_age == '1) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= '1;
          1:       stall_pat <= (16'($urandom) & 16'($urandom)) | 16'h0001;
          default: stall_pat <= 16'($urandom) | 16'h0001;
        endcase
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
